/* hdl/ghr_pkg.sv */
// shared types and constants for the generational handle registry
`default_nettype none
package ghr_pkg;

    // default table size
    localparam int SLOT_COUNT_DEFAULT = 64;

    // field widths
    localparam int REQ_W    = 3;
    localparam int HANDLE_W = 64;
    localparam int REF_W    = 48;
    localparam int GEN_W    = 16;
    localparam int STAT_W   = 3;
    localparam int NH_W     = 48;
    localparam int LIVE_W   = 7;
    localparam int SLOTF_W  = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INIT       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SHUTDOWN   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ARG    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 3'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 3'd5;

    // update command for the occupancy map
    typedef struct packed {
        logic clear_all;
        logic set_en;
        logic clr_en;
    } ghr_map_cmd_t;

    // command for the slot memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_gen;
    } ghr_mem_cmd_t;

endpackage
`default_nettype wire

/* hdl/ghr_free_map.sv */
// occupancy bits per slot and lowest free slot search
`default_nettype none
module ghr_free_map #(
    parameter int SLOT_COUNT = ghr_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  ghr_pkg::ghr_map_cmd_t       cmd,
    input  wire  [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] idx,
    output logic [SLOT_COUNT-1:0]       valid,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] free_idx,
    output logic                        free_found
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [SLOT_COUNT-1:0] valid_reg;

    assign valid = valid_reg;

    // occupancy update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            valid_reg <= '0;
        end
        else if (cmd.set_en)
        begin
            valid_reg[idx] <= 1'b1;
        end
        else if (cmd.clr_en)
        begin
            valid_reg[idx] <= 1'b0;
        end
    end

    // lowest clear bit wins
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/ghr_slot_mem.sv */
// slot memory holding generation and stored reference per slot
`default_nettype none
module ghr_slot_mem #(
    parameter int SLOT_COUNT = ghr_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  ghr_pkg::ghr_mem_cmd_t        cmd,
    input  wire  [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
    input  wire  [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_addr,
    input  wire  [ghr_pkg::GEN_W-1:0]    wr_gen,
    input  wire  [ghr_pkg::REF_W-1:0]    wr_ref,
    output logic [ghr_pkg::GEN_W-1:0]    rd_gen,
    output logic [ghr_pkg::REF_W-1:0]    rd_ref
);

    localparam int WORD_W = ghr_pkg::GEN_W + ghr_pkg::REF_W;

    logic [WORD_W-1:0]     mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] gen_live_reg;
    logic [WORD_W-1:0]     rd_word_reg;
    logic                  rd_live_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= {wr_gen, wr_ref};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            rd_live_reg <= gen_live_reg[rd_addr];
        end
    end

    // a slot whose generation was never written since init reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_live_reg <= '0;
        end
        else if (cmd.clear_gen)
        begin
            gen_live_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            gen_live_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_gen = rd_live_reg ? rd_word_reg[WORD_W-1:ghr_pkg::REF_W] : '0;
    assign rd_ref = rd_word_reg[ghr_pkg::REF_W-1:0];

endmodule
`default_nettype wire

/* hdl/generational_handle_registry.sv */
// Generational handle registry: a table of SLOT_COUNT slots that issues
// generation-tagged handles (generation in bits 47:32, slot in bits 31:0).
// Each request passes the accept cycle and then S_EXEC: the accept cycle
// picks the slot (lowest free one from the occupancy bits for register,
// the handle's slot otherwise) and starts a read of the slot memory;
// S_EXEC checks the registered generation, writes back and loads the
// result register. A new request is taken only in S_IDLE, so the block
// does not accept one until the last has loaded its result. The result
// register lets the next request be accepted while a result still waits;
// a stalled result holds S_EXEC until it is taken. Init clears generations
// through per-slot flags, so no clearing pass is run after reset or init.
`default_nettype none
module generational_handle_registry #(
    parameter int SLOT_COUNT = ghr_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire          clk,
    input  wire          rst_n,
    // request channel
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [111:0] s_tdata,   // handle[63:0], entry_ref[111:64]
    input  wire  [2:0]   s_tuser,   // req_type[2:0]
    // result channel
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [111:0] m_tdata    // status[2:0], new_handle[50:3],
                                    // found_ref[98:51], live_count[105:99],
                                    // zero[111:106]
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = ($clog2(SLOT_COUNT + 1) > ghr_pkg::LIVE_W)
                           ? $clog2(SLOT_COUNT + 1) : ghr_pkg::LIVE_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg, state_next;
    logic                            active_reg, active_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            m_valid_reg, m_valid_next;
    logic [ghr_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [ghr_pkg::NH_W-1:0]        nh_reg, nh_next;
    logic [ghr_pkg::REF_W-1:0]       fr_reg, fr_next;

    // request held across the memory read
    logic [ghr_pkg::REQ_W-1:0]       req_reg;
    logic [ghr_pkg::HANDLE_W-1:0]    handle_reg;
    logic [ghr_pkg::REF_W-1:0]       ref_reg;
    logic [IDX_W-1:0]                slot_reg;
    logic                            hit_ok_reg;

    logic [ghr_pkg::REQ_W-1:0]       in_req;
    logic [ghr_pkg::HANDLE_W-1:0]    in_handle;
    logic [ghr_pkg::REF_W-1:0]       in_ref;
    logic                            in_xfer;
    logic [IDX_W-1:0]                rd_addr;
    logic                            in_range;

    logic [SLOT_COUNT-1:0]           valid;
    logic [IDX_W-1:0]                free_idx;
    logic                            free_found;
    logic [ghr_pkg::GEN_W-1:0]       rd_gen;
    logic [ghr_pkg::REF_W-1:0]       rd_ref;
    logic [ghr_pkg::GEN_W-1:0]       gen_bump;

    ghr_pkg::ghr_map_cmd_t           map_cmd;
    ghr_pkg::ghr_mem_cmd_t           mem_cmd;
    logic                            commit;
    logic                            handle_match;

    assign in_req    = s_tuser;
    assign in_handle = s_tdata[63:0];
    assign in_ref    = s_tdata[111:64];

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // slot selection at the accept cycle
    assign in_range = in_handle[ghr_pkg::SLOTF_W-1:0] < ghr_pkg::SLOTF_W'(SLOT_COUNT);
    assign rd_addr  = (in_req == ghr_pkg::REQ_REGISTER) ? free_idx
                                                         : in_handle[IDX_W-1:0];

    ghr_free_map #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_free_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (map_cmd),
        .idx        (slot_reg),
        .valid      (valid),
        .free_idx   (free_idx),
        .free_found (free_found)
    );

    ghr_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_addr (rd_addr),
        .wr_addr (slot_reg),
        .wr_gen  (gen_bump),
        .wr_ref  (ref_reg),
        .rd_gen  (rd_gen),
        .rd_ref  (rd_ref)
    );

    // capture the request; hit_ok records free slot or in-range handle
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg    <= in_req;
            handle_reg <= in_handle;
            ref_reg    <= in_ref;
            slot_reg   <= rd_addr;
            hit_ok_reg <= (in_req == ghr_pkg::REQ_REGISTER) ? free_found : in_range;
        end
    end

    // next generation, zero skipped
    always_comb
    begin
        gen_bump = rd_gen + ghr_pkg::GEN_W'(1);
        if (gen_bump == '0)
        begin
            gen_bump = ghr_pkg::GEN_W'(1);
        end
    end

    assign handle_match = hit_ok_reg && valid[slot_reg]
                          && (rd_gen == handle_reg[47:32]);

    // result may be loaded when the result register is empty or draining
    assign commit = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    // request evaluation and state update
    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        nh_next      = nh_reg;
        fr_next      = fr_reg;
        map_cmd      = '0;
        mem_cmd      = '0;
        mem_cmd.rd_en = in_xfer;

        if (in_xfer)
        begin
            state_next = S_EXEC;
        end

        if (commit)
        begin
            state_next   = S_IDLE;
            m_valid_next = 1'b1;
            status_next  = ghr_pkg::ST_OK;
            nh_next      = '0;
            fr_next      = '0;
            case (req_reg)
                ghr_pkg::REQ_INIT:
                begin
                    if (active_reg)
                    begin
                        status_next = ghr_pkg::ST_ALREADY;
                    end
                    else
                    begin
                        map_cmd.clear_all = 1'b1;
                        mem_cmd.clear_gen = 1'b1;
                        count_next        = '0;
                        active_next       = 1'b1;
                    end
                end
                ghr_pkg::REQ_SHUTDOWN:
                begin
                    if (!active_reg)
                    begin
                        status_next = ghr_pkg::ST_NOT_ACTIVE;
                    end
                    else
                    begin
                        map_cmd.clear_all = 1'b1;
                        count_next        = '0;
                        active_next       = 1'b0;
                    end
                end
                ghr_pkg::REQ_REGISTER:
                begin
                    if (ref_reg == '0)
                    begin
                        status_next = ghr_pkg::ST_BAD_ARG;
                    end
                    else if (!active_reg)
                    begin
                        status_next = ghr_pkg::ST_NOT_ACTIVE;
                    end
                    else if (!hit_ok_reg)
                    begin
                        status_next = ghr_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_cmd.wr_en  = 1'b1;
                        map_cmd.set_en = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                        nh_next        = {gen_bump, ghr_pkg::SLOTF_W'(slot_reg)};
                    end
                end
                ghr_pkg::REQ_LOOKUP,
                ghr_pkg::REQ_UNREGISTER:
                begin
                    if (handle_reg == '0)
                    begin
                        status_next = ghr_pkg::ST_BAD_ARG;
                    end
                    else if (!active_reg)
                    begin
                        status_next = ghr_pkg::ST_NOT_ACTIVE;
                    end
                    else if (!handle_match)
                    begin
                        status_next = ghr_pkg::ST_BAD_HANDLE;
                    end
                    else if (req_reg == ghr_pkg::REQ_LOOKUP)
                    begin
                        fr_next = rd_ref;
                    end
                    else
                    begin
                        map_cmd.clr_en = 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    status_next = ghr_pkg::ST_BAD_ARG;
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= '0;
            nh_reg      <= '0;
            fr_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            nh_reg      <= nh_next;
            fr_reg      <= fr_next;
        end
    end

    // result transfer packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, count_reg[ghr_pkg::LIVE_W-1:0], fr_reg, nh_reg, status_reg};

endmodule
`default_nettype wire

/* bench/generational_handle_registry_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the generational handle registry
module generational_handle_registry_tb;

    localparam int SLOTS        = ghr_pkg::SLOT_COUNT_DEFAULT;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DATA_W       = 112;

    // result field offsets inside m_tdata
    localparam int NH_LSB  = ghr_pkg::STAT_W;
    localparam int FR_LSB  = NH_LSB + ghr_pkg::NH_W;
    localparam int LC_LSB  = FR_LSB + ghr_pkg::REF_W;
    localparam int PAD_LSB = LC_LSB + ghr_pkg::LIVE_W;

    // request codes with no meaning to the block
    localparam logic [ghr_pkg::REQ_W-1:0] REQ_UNKNOWN_LO = ghr_pkg::REQ_UNREGISTER + 3'd1;
    localparam logic [ghr_pkg::REQ_W-1:0] REQ_UNKNOWN_HI = {ghr_pkg::REQ_W{1'b1}};

    typedef struct {
        logic [ghr_pkg::STAT_W-1:0] status;
        logic [ghr_pkg::NH_W-1:0]   new_handle;
        logic [ghr_pkg::REF_W-1:0]  found_ref;
        logic [ghr_pkg::LIVE_W-1:0] live_count;
    } registry_result_t;

    // shadow copy of the slot table and the queue of awaited results
    class handle_table_scoreboard;
        bit                       slot_used[SLOTS];
        bit [ghr_pkg::GEN_W-1:0]  slot_gen[SLOTS];
        bit [ghr_pkg::REF_W-1:0]  slot_entry[SLOTS];
        int unsigned              in_use;
        bit                       active;
        registry_result_t         awaited[$];
        logic [ghr_pkg::NH_W-1:0] live_handles[$];
        logic [ghr_pkg::NH_W-1:0] stale_handles[$];
        int                       errors;

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("%0t ns  mismatch: %s", $time, msg);
        endtask

        function int lowest_free();
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_used[i])
                    return i;
            end
            return -1;
        endfunction

        // slot named by a handle, or -1 when it names no live entry
        function int slot_of(logic [ghr_pkg::HANDLE_W-1:0] h);
            int idx;
            if (h[ghr_pkg::SLOTF_W-1:0] >= SLOTS)
                return -1;
            idx = int'(h[ghr_pkg::SLOTF_W-1:0]);
            if (!slot_used[idx] || slot_gen[idx] != h[ghr_pkg::SLOTF_W +: ghr_pkg::GEN_W])
                return -1;
            return idx;
        endfunction

        function void forget_handle(logic [ghr_pkg::NH_W-1:0] h);
            for (int i = 0; i < live_handles.size(); i++)
            begin
                if (live_handles[i] == h)
                begin
                    live_handles.delete(i);
                    break;
                end
            end
            stale_handles.push_back(h);
            if (stale_handles.size() > 16)
                void'(stale_handles.pop_front());
        endfunction

        function void drop_all_slots();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            in_use = 0;
            live_handles.delete();
            stale_handles.delete();
        endfunction

        // predict the result of one accepted request and update the shadow
        function void note_request(logic [ghr_pkg::REQ_W-1:0] req,
                                   logic [ghr_pkg::HANDLE_W-1:0] handle,
                                   logic [ghr_pkg::REF_W-1:0] entry_ref);
            registry_result_t        r;
            int                      slot;
            bit [ghr_pkg::GEN_W-1:0] g;
            r.status     = ghr_pkg::ST_OK;
            r.new_handle = '0;
            r.found_ref  = '0;
            case (req)
                ghr_pkg::REQ_INIT:
                    if (active)
                        r.status = ghr_pkg::ST_ALREADY;
                    else
                    begin
                        drop_all_slots();
                        foreach (slot_gen[i])
                            slot_gen[i] = '0;
                        active = 1'b1;
                    end
                ghr_pkg::REQ_SHUTDOWN:
                    if (!active)
                        r.status = ghr_pkg::ST_NOT_ACTIVE;
                    else
                    begin
                        // generations survive a shutdown
                        drop_all_slots();
                        active = 1'b0;
                    end
                ghr_pkg::REQ_REGISTER:
                    if (entry_ref == '0)
                        r.status = ghr_pkg::ST_BAD_ARG;
                    else if (!active)
                        r.status = ghr_pkg::ST_NOT_ACTIVE;
                    else
                    begin
                        slot = lowest_free();
                        if (slot < 0)
                            r.status = ghr_pkg::ST_FULL;
                        else
                        begin
                            // generation skips zero on wrap
                            g = slot_gen[slot] + 1'b1;
                            if (g == '0)
                                g = ghr_pkg::GEN_W'(1);
                            slot_gen[slot]   = g;
                            slot_entry[slot] = entry_ref;
                            slot_used[slot]  = 1'b1;
                            in_use++;
                            r.new_handle = {g, 32'(slot)};
                            live_handles.push_back(r.new_handle);
                        end
                    end
                ghr_pkg::REQ_LOOKUP, ghr_pkg::REQ_UNREGISTER:
                    if (handle == '0)
                        r.status = ghr_pkg::ST_BAD_ARG;
                    else if (!active)
                        r.status = ghr_pkg::ST_NOT_ACTIVE;
                    else
                    begin
                        slot = slot_of(handle);
                        if (slot < 0)
                            r.status = ghr_pkg::ST_BAD_HANDLE;
                        else if (req == ghr_pkg::REQ_LOOKUP)
                            r.found_ref = slot_entry[slot];
                        else
                        begin
                            slot_used[slot] = 1'b0;
                            if (in_use > 0)
                                in_use--;
                            forget_handle(handle[ghr_pkg::NH_W-1:0]);
                        end
                    end
                default:
                    r.status = ghr_pkg::ST_BAD_ARG;
            endcase
            r.live_count = in_use[ghr_pkg::LIVE_W-1:0];
            awaited.push_back(r);
        endfunction

        // compare one result transfer with the oldest prediction
        task check_result(logic [DATA_W-1:0] d);
            registry_result_t want;
            if (awaited.size() == 0)
                report_mismatch($sformatf("result %h with nothing outstanding", d));
            else
            begin
                want = awaited.pop_front();
                if (d[ghr_pkg::STAT_W-1:0] !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              d[ghr_pkg::STAT_W-1:0], want.status));
                if (d[NH_LSB +: ghr_pkg::NH_W] !== want.new_handle)
                    report_mismatch($sformatf("new_handle %h, predicted %h",
                                              d[NH_LSB +: ghr_pkg::NH_W],
                                              want.new_handle));
                if (d[FR_LSB +: ghr_pkg::REF_W] !== want.found_ref)
                    report_mismatch($sformatf("found_ref %h, predicted %h",
                                              d[FR_LSB +: ghr_pkg::REF_W],
                                              want.found_ref));
                if (d[LC_LSB +: ghr_pkg::LIVE_W] !== want.live_count)
                    report_mismatch($sformatf("live_count %0d, predicted %0d",
                                              d[LC_LSB +: ghr_pkg::LIVE_W],
                                              want.live_count));
                if (d[DATA_W-1:PAD_LSB] !== '0)
                    report_mismatch($sformatf("padding bits %h not zero",
                                              d[DATA_W-1:PAD_LSB]));
            end
        endtask
    endclass

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [DATA_W-1:0]          s_tdata  = '0;
    logic [ghr_pkg::REQ_W-1:0]  s_tuser  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [DATA_W-1:0]          m_tdata;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;

    handle_table_scoreboard sb;

    generational_handle_registry dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // reset held low from the start, released on a falling edge
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    // result checking and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [ghr_pkg::HANDLE_W-1:0] rand_handle();
        return {$urandom, $urandom};
    endfunction

    // random non-null reference, with the extremes now and then
    function automatic logic [ghr_pkg::REF_W-1:0] rand_ref();
        logic [ghr_pkg::REF_W-1:0] r;
        r = ghr_pkg::REF_W'({$urandom, $urandom});
        case ($urandom_range(15))
            0: r = '1;
            1: r = ghr_pkg::REF_W'(1);
            default: ;
        endcase
        if (r == '0)
            r = ghr_pkg::REF_W'(1);
        return r;
    endfunction

    // request transfer with random idle cycles ahead of it
    task automatic send_req(logic [ghr_pkg::REQ_W-1:0] req,
                            logic [ghr_pkg::HANDLE_W-1:0] handle,
                            logic [ghr_pkg::REF_W-1:0] entry_ref);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {entry_ref, handle};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req, handle, entry_ref);
        items_sent++;
    endtask

    // a live handle with junk in the ignored top bits
    function automatic logic [ghr_pkg::HANDLE_W-1:0] pick_live();
        int k;
        k = $urandom_range(sb.live_handles.size() - 1);
        return {16'($urandom), sb.live_handles[k]};
    endfunction

    function automatic logic [ghr_pkg::HANDLE_W-1:0] noise_handle();
        case ($urandom_range(3))
            0: return '0;
            1: return rand_handle();
            default: return {16'($urandom), 16'($urandom_range(3)),
                             32'($urandom_range(SLOTS))};
        endcase
    endfunction

    // edge cases in a fixed order
    task automatic directed_checks();
        logic [ghr_pkg::HANDLE_W-1:0] slot0_gen1;
        logic [ghr_pkg::HANDLE_W-1:0] slot0_gen2;
        slot0_gen1 = {32'd1, 32'd0};
        slot0_gen2 = {32'd2, 32'd0};
        // requests while inactive, argument checks first
        send_req(ghr_pkg::REQ_REGISTER, rand_handle(), rand_ref());
        send_req(ghr_pkg::REQ_REGISTER, rand_handle(), '0);
        send_req(ghr_pkg::REQ_LOOKUP, '0, rand_ref());
        send_req(ghr_pkg::REQ_UNREGISTER, slot0_gen1, rand_ref());
        send_req(ghr_pkg::REQ_SHUTDOWN, rand_handle(), rand_ref());
        send_req(REQ_UNKNOWN_HI, rand_handle(), rand_ref());
        send_req(ghr_pkg::REQ_INIT, rand_handle(), rand_ref());
        send_req(ghr_pkg::REQ_INIT, rand_handle(), rand_ref());
        // extreme references in the first two slots
        send_req(ghr_pkg::REQ_REGISTER, '0, '1);
        send_req(ghr_pkg::REQ_REGISTER, '1, ghr_pkg::REF_W'(1));
        send_req(ghr_pkg::REQ_LOOKUP, {16'hFFFF, slot0_gen1[47:0]}, rand_ref());
        send_req(ghr_pkg::REQ_LOOKUP, slot0_gen2, rand_ref());
        send_req(ghr_pkg::REQ_LOOKUP, {32'd1, 32'hFFFF_FFFF}, rand_ref());
        send_req(ghr_pkg::REQ_LOOKUP, {32'd1, 32'(SLOTS)}, rand_ref());
        send_req(ghr_pkg::REQ_LOOKUP, {32'd0, 32'd2}, rand_ref());
        // free, stale reuse, reissue with the next generation
        send_req(ghr_pkg::REQ_UNREGISTER, slot0_gen1, rand_ref());
        send_req(ghr_pkg::REQ_UNREGISTER, slot0_gen1, rand_ref());
        send_req(ghr_pkg::REQ_REGISTER, rand_handle(), rand_ref());
        send_req(ghr_pkg::REQ_LOOKUP, slot0_gen2, rand_ref());
        send_req(ghr_pkg::REQ_REGISTER, rand_handle(), '0);
        send_req(ghr_pkg::REQ_UNREGISTER, '0, rand_ref());
        send_req(REQ_UNKNOWN_LO, rand_handle(), rand_ref());
        send_req(REQ_UNKNOWN_LO + 3'd1, rand_handle(), rand_ref());
        send_req(ghr_pkg::REQ_SHUTDOWN, rand_handle(), rand_ref());
        send_req(ghr_pkg::REQ_LOOKUP, slot0_gen2, rand_ref());
        send_req(ghr_pkg::REQ_INIT, rand_handle(), rand_ref());
    endtask

    // mostly well-formed traffic on live handles, plus noise
    task automatic random_phase(int count);
        int target;
        int pick;
        int burst;
        logic [ghr_pkg::HANDLE_W-1:0] h;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (!sb.active && $urandom_range(9) != 0)
                send_req(ghr_pkg::REQ_INIT, rand_handle(), rand_ref());
            else if (pick < 22)
            begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                    send_req(ghr_pkg::REQ_REGISTER, rand_handle(), rand_ref());
            end
            else if (pick < 46 && sb.live_handles.size() != 0)
                send_req(ghr_pkg::REQ_LOOKUP, pick_live(), rand_ref());
            else if (pick < 64)
            begin
                burst = $urandom_range(1, 3);
                repeat (burst)
                begin
                    if (sb.live_handles.size() != 0)
                        send_req(ghr_pkg::REQ_UNREGISTER, pick_live(), rand_ref());
                end
            end
            else if (pick < 71 && sb.stale_handles.size() != 0)
            begin
                h = {16'($urandom),
                     sb.stale_handles[$urandom_range(sb.stale_handles.size() - 1)]};
                send_req($urandom_range(1) ? ghr_pkg::REQ_LOOKUP : ghr_pkg::REQ_UNREGISTER,
                         h, rand_ref());
            end
            else if (pick < 77 && sb.live_handles.size() != 0)
            begin
                // one flipped bit in generation or slot
                h = pick_live() ^ (64'd1 << $urandom_range(ghr_pkg::NH_W - 1));
                send_req($urandom_range(1) ? ghr_pkg::REQ_LOOKUP : ghr_pkg::REQ_UNREGISTER,
                         h, rand_ref());
            end
            else if (pick < 79)
            begin
                // fill every slot, then one more to hit the full case
                while (sb.active && sb.in_use < SLOTS)
                    send_req(ghr_pkg::REQ_REGISTER, rand_handle(), rand_ref());
                send_req(ghr_pkg::REQ_REGISTER, rand_handle(), rand_ref());
            end
            else if (pick < 81)
                send_req(ghr_pkg::REQ_SHUTDOWN, rand_handle(), rand_ref());
            else
                send_req(3'($urandom_range(7)), noise_handle(),
                         $urandom_range(7) == 0 ? '0 : rand_ref());
        end
    endtask

    initial
    begin
        sb = new();
        wait (rst_n);
        directed_checks();
        // idling phases: none, sender, receiver, both
        random_phase(RANDOM_ITEMS / 4);
        src_idle_pct = 83;
        random_phase(RANDOM_ITEMS / 4);
        src_idle_pct   = 0;
        sink_stall_pct = 83;
        random_phase(RANDOM_ITEMS / 4);
        src_idle_pct   = 12;
        sink_stall_pct = 12;
        random_phase(RANDOM_ITEMS / 4);
        @(negedge clk);
        s_tvalid = 1'b0;
        // drain outstanding results, then wait for stray transfers
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* generational_handle_registry.f */
hdl/ghr_pkg.sv
hdl/ghr_free_map.sv
hdl/ghr_slot_mem.sv
hdl/generational_handle_registry.sv
bench/generational_handle_registry_tb.sv
